FILE: hdl/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// Types, codes and helper functions shared by the packet latency tracker.
// ----------------------------------------------------------------------------
package plt_pkg;

    // event opcodes
    localparam logic [1:0] OP_ARRIVAL = 2'd0;
    localparam logic [1:0] OP_INGRESS = 2'd1;
    localparam logic [1:0] OP_EGRESS  = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    // statistic selectors
    localparam logic [3:0] SEL_PACKETS  = 4'd0;
    localparam logic [3:0] SEL_BYTES    = 4'd1;
    localparam logic [3:0] SEL_LAT_SUM  = 4'd2;
    localparam logic [3:0] SEL_LAT_MIN  = 4'd3;
    localparam logic [3:0] SEL_LAT_MAX  = 4'd4;
    localparam logic [3:0] SEL_HOOK_ARR = 4'd5;
    localparam logic [3:0] SEL_HOOK_ING = 4'd6;
    localparam logic [3:0] SEL_HOOK_EGR = 4'd7;
    localparam logic [3:0] SEL_HIST     = 4'd8;
    localparam logic [3:0] SEL_GLB_CNT  = 4'd9;
    localparam logic [3:0] SEL_GLB_SUM  = 4'd10;

    localparam int NUM_BUCKETS = 16;
    localparam logic [63:0] NS_PER_US = 64'd1000;
    localparam logic [63:0] TOP_BUCKET_NS = 64'd16384000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] flow_hash;
        logic [7:0]  iface;
        logic [15:0] pkt_len;
        logic [63:0] now_ns;
        logic [3:0]  stat_select;
        logic [7:0]  stat_index;
    } in_item_t;

    typedef struct packed {
        logic        ignored;
        logic        matched;
        logic [63:0] latency;
        logic [3:0]  bucket;
        logic [63:0] read_data;
    } out_item_t;

    // one arrival table entry
    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic [63:0] time_ns;
    } arr_entry_t;

    // one interface counter row
    typedef struct packed {
        logic [63:0] packets;
        logic [63:0] bytes;
        logic [63:0] lat_sum;
        logic [63:0] lat_min;
        logic [63:0] lat_max;
        logic [63:0] hook_arr;
        logic [63:0] hook_ing;
        logic [63:0] hook_egr;
    } iface_row_t;

    // log2 microsecond bucket by compare against fixed thresholds
    function automatic logic [3:0] bucket_of(input logic [63:0] lat);
        logic [3:0] b;
        b = 4'd0;
        for (int k = 0; k < 14; k++) begin
            if (lat >= (NS_PER_US << k)) begin
                b = 4'(k + 1);
            end
        end
        if (lat >= TOP_BUCKET_NS) begin
            b = 4'd15;
        end
        return b;
    endfunction

endpackage

FILE: hdl/packet_latency_tracker.sv
// ----------------------------------------------------------------------------
// packet_latency_tracker
// Arrival timestamp table with latency histogram and per-interface counters.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. With a power-of-two ARRIVAL_ENTRIES
// it passes through table read, latency subtract, bucket compare and write
// back; otherwise the slot is first found by a reciprocal multiply and a
// remainder step. The arrival table and the interface counter rows are
// single-port memories, each read once and written back at most once per
// transaction. After reset a clearing pass empties the arrival table entry by
// entry; s_ready stays low until it is done. A new transaction may be accepted
// while the previous result still waits on m_ready; it then waits in write
// back until the result register is free.
module packet_latency_tracker #(
    parameter int ARRIVAL_ENTRIES = 4096,
    parameter int IFACE_ENTRIES   = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  plt_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output plt_pkg::out_item_t   m_data
);

    localparam int AW = (ARRIVAL_ENTRIES > 1) ? $clog2(ARRIVAL_ENTRIES) : 1;
    localparam int IW = (IFACE_ENTRIES > 1) ? $clog2(IFACE_ENTRIES) : 1;
    localparam bit POW2 = (ARRIVAL_ENTRIES & (ARRIVAL_ENTRIES - 1)) == 0;
    localparam logic [AW-1:0] ARR_LAST = AW'(ARRIVAL_ENTRIES - 1);
    localparam logic [8:0] IF_N = 9'(IFACE_ENTRIES);
    localparam int NUM_HIST = plt_pkg::NUM_BUCKETS;
    // ceil(2^(32+AW) / ARRIVAL_ENTRIES), exact quotient for any 32-bit hash
    localparam logic [63:0] RECIP_W = ((64'd1 << (32 + AW)) + 64'(ARRIVAL_ENTRIES)
                                       - 64'd1) / 64'(ARRIVAL_ENTRIES);
    localparam logic [32:0] RECIP = RECIP_W[32:0];

    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_REM, S_RD, S_LOOK, S_CALC, S_WB
    } state_t;

    state_t               state_reg;
    plt_pkg::in_item_t    item_reg;
    logic [AW-1:0]        slot_reg;
    logic [31:0]          quot_reg;
    logic [IW-1:0]        ifaddr_reg;
    logic                 if_in_range_reg;
    logic                 clr_busy_reg;
    logic [AW-1:0]        clr_cnt_reg;
    logic                 hit_reg;
    logic [63:0]          lat_reg;
    logic [3:0]           bkt_reg;
    logic [IFACE_ENTRIES-1:0] seen_reg;
    logic [63:0]          hist_reg [NUM_HIST];
    logic [63:0]          glb_cnt_reg;
    logic [63:0]          glb_sum_reg;

    // memories
    plt_pkg::arr_entry_t  arr_mem [ARRIVAL_ENTRIES];
    plt_pkg::iface_row_t  if_mem  [IFACE_ENTRIES];
    plt_pkg::arr_entry_t  arr_q;
    plt_pkg::iface_row_t  if_q;

    logic                 is_event;
    logic                 ignored;
    logic                 advance;
    logic [64:0]          mod_prod;
    logic [31:0]          mod_rem;
    logic                 arr_we;
    plt_pkg::arr_entry_t  arr_wd;
    logic                 if_we;
    plt_pkg::iface_row_t  if_base;
    plt_pkg::iface_row_t  if_wd;
    logic                 if_seen;
    logic [63:0]          rd_data;
    logic [7:0]           s_addr;

    assign s_ready  = (state_reg == S_IDLE) && !clr_busy_reg;
    assign is_event = item_reg.opcode != plt_pkg::OP_READ;
    assign ignored  = is_event && (item_reg.flow_hash == 32'd0);
    assign advance  = !m_valid || m_ready;
    assign mod_prod = 65'(item_reg.flow_hash) * 65'(RECIP);
    assign mod_rem  = item_reg.flow_hash - quot_reg * 32'(ARRIVAL_ENTRIES);
    assign if_seen  = seen_reg[ifaddr_reg] && if_in_range_reg;
    assign s_addr   = (s_data.opcode == plt_pkg::OP_READ) ? s_data.stat_index
                                                          : s_data.iface;

    // arrival table write data
    always_comb begin
        arr_we = 1'b0;
        arr_wd = arr_q;
        if (state_reg == S_WB && advance && !ignored && is_event) begin
            if (item_reg.opcode == plt_pkg::OP_ARRIVAL) begin
                arr_we = 1'b1;
                arr_wd = '{valid: 1'b1, tag: item_reg.flow_hash,
                           time_ns: item_reg.now_ns};
            end else if (hit_reg && item_reg.opcode == plt_pkg::OP_EGRESS) begin
                arr_we = 1'b1;
                arr_wd.valid = 1'b0;
            end
        end
    end

    // interface row update
    always_comb begin
        if_base = if_q;
        if (!seen_reg[ifaddr_reg]) begin
            if_base = '0;
            if_base.lat_min = (lat_reg != 64'd0) ? lat_reg : '1;
            if_base.lat_max = lat_reg;
        end
        if_wd = if_base;
        if_wd.packets = if_base.packets + 64'd1;
        if_wd.bytes   = if_base.bytes + 64'(item_reg.pkt_len);
        if (lat_reg != 64'd0) begin
            if_wd.lat_sum = if_base.lat_sum + lat_reg;
            if (lat_reg < if_base.lat_min || if_base.lat_min == 64'd0) begin
                if_wd.lat_min = lat_reg;
            end
            if (lat_reg > if_base.lat_max) begin
                if_wd.lat_max = lat_reg;
            end
        end
        case (item_reg.opcode)
            plt_pkg::OP_ARRIVAL: if_wd.hook_arr = if_base.hook_arr + 64'd1;
            plt_pkg::OP_INGRESS: if_wd.hook_ing = if_base.hook_ing + 64'd1;
            plt_pkg::OP_EGRESS:  if_wd.hook_egr = if_base.hook_egr + 64'd1;
            default:             if_wd = if_base;
        endcase
        if_we = (state_reg == S_WB) && advance && is_event && !ignored
                && if_in_range_reg;
    end

    // statistic read mux
    always_comb begin
        rd_data = 64'd0;
        case (item_reg.stat_select)
            plt_pkg::SEL_PACKETS:  rd_data = if_q.packets;
            plt_pkg::SEL_BYTES:    rd_data = if_q.bytes;
            plt_pkg::SEL_LAT_SUM:  rd_data = if_q.lat_sum;
            plt_pkg::SEL_LAT_MIN:  rd_data = if_q.lat_min;
            plt_pkg::SEL_LAT_MAX:  rd_data = if_q.lat_max;
            plt_pkg::SEL_HOOK_ARR: rd_data = if_q.hook_arr;
            plt_pkg::SEL_HOOK_ING: rd_data = if_q.hook_ing;
            plt_pkg::SEL_HOOK_EGR: rd_data = if_q.hook_egr;
            plt_pkg::SEL_HIST:
                rd_data = (item_reg.stat_index < 8'(NUM_HIST))
                        ? hist_reg[item_reg.stat_index[3:0]] : 64'd0;
            plt_pkg::SEL_GLB_CNT:  rd_data = glb_cnt_reg;
            plt_pkg::SEL_GLB_SUM:  rd_data = glb_sum_reg;
            default:               rd_data = 64'd0;
        endcase
        if (item_reg.stat_select < plt_pkg::SEL_HIST && !if_seen) begin
            rd_data = 64'd0;
        end
    end

    // arrival table port, clearing pass has priority
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            arr_mem[clr_cnt_reg] <= '0;
        end else if (arr_we) begin
            arr_mem[slot_reg] <= arr_wd;
        end
        if (state_reg == S_RD) begin
            arr_q <= arr_mem[slot_reg];
        end
    end

    // interface counter port
    always_ff @(posedge aclk) begin
        if (if_we) begin
            if_mem[ifaddr_reg] <= if_wd;
        end
        if (state_reg == S_RD) begin
            if_q <= if_mem[ifaddr_reg];
        end
    end

    // control, statistics and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            seen_reg     <= '0;
            glb_cnt_reg  <= '0;
            glb_sum_reg  <= '0;
            m_valid      <= 1'b0;
            for (int i = 0; i < NUM_HIST; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            if (clr_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == ARR_LAST) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (m_valid && m_ready && state_reg != S_WB) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        item_reg        <= s_data;
                        ifaddr_reg      <= IW'(s_addr);
                        if_in_range_reg <= {1'b0, s_addr} < IF_N;
                        if (POW2) begin
                            slot_reg  <= AW'(s_data.flow_hash);
                            state_reg <= S_RD;
                        end else begin
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    // quotient by reciprocal multiply
                    quot_reg  <= 32'(mod_prod >> (32 + AW));
                    state_reg <= S_REM;
                end
                S_REM: begin
                    slot_reg  <= AW'(mod_rem);
                    state_reg <= S_RD;
                end
                S_RD: begin
                    state_reg <= S_LOOK;
                end
                S_LOOK: begin
                    hit_reg <= is_event && !ignored
                            && item_reg.opcode != plt_pkg::OP_ARRIVAL
                            && arr_q.valid && arr_q.tag == item_reg.flow_hash
                            && arr_q.time_ns != 64'd0;
                    lat_reg <= item_reg.now_ns - arr_q.time_ns;
                    state_reg <= S_CALC;
                end
                S_CALC: begin
                    if (!hit_reg) begin
                        lat_reg <= 64'd0;
                    end
                    bkt_reg   <= hit_reg ? plt_pkg::bucket_of(lat_reg) : 4'd0;
                    state_reg <= S_WB;
                end
                S_WB: begin
                    if (advance) begin
                        if (hit_reg) begin
                            hist_reg[bkt_reg] <= hist_reg[bkt_reg] + 64'd1;
                            glb_cnt_reg       <= glb_cnt_reg + 64'd1;
                            glb_sum_reg       <= glb_sum_reg + lat_reg;
                        end
                        if (if_we) begin
                            seen_reg[ifaddr_reg] <= 1'b1;
                        end
                        m_valid           <= 1'b1;
                        m_data.ignored    <= ignored;
                        m_data.matched    <= hit_reg;
                        m_data.latency    <= lat_reg;
                        m_data.bucket     <= bkt_reg;
                        m_data.read_data  <= is_event ? 64'd0 : rd_data;
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/plt_checker.sv
// ----------------------------------------------------------------------------
// plt_checker
// Port-level checks on the packet latency tracker result channel.
// ----------------------------------------------------------------------------
module plt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input plt_pkg::out_item_t m_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // an ignored transaction never matches
    a_ign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.ignored |-> !m_data.matched && m_data.latency == 64'd0)
        else $error("ignored transaction reported a match");

    // unmatched results carry no bucket and no latency
    a_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.matched |-> m_data.bucket == 4'd0
            && m_data.latency == 64'd0)
        else $error("unmatched result with latency");

    // a match is never a read answer
    a_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.matched |-> m_data.read_data == 64'd0)
        else $error("match carried read data");

endmodule

bind packet_latency_tracker plt_checker u_plt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: sim/tb_packet_latency_tracker.sv
// ----------------------------------------------------------------------------
// tb_packet_latency_tracker
// Self-checking bench for the packet latency tracker: directed and random
// event streams, an in-bench latency/counter predictor, and a per-field
// scoreboard under several sender and receiver idling phases.
// ----------------------------------------------------------------------------
module tb_packet_latency_tracker;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SLOTS      = 4096;
    localparam int  IFACES     = 256;
    localparam int  HIST_SIZE  = 16;
    localparam int  N_RANDOM   = 780;
    localparam longint CYCLE_LIMIT = 400000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    plt_pkg::in_item_t   s_data;
    logic                m_valid;
    logic                m_ready;
    plt_pkg::out_item_t  m_data;

    packet_latency_tracker #(
        .ARRIVAL_ENTRIES(SLOTS),
        .IFACE_ENTRIES  (IFACES)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // clock
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // predictor state
    logic        slot_valid [SLOTS];
    logic [31:0] slot_tag   [SLOTS];
    logic [63:0] slot_time  [SLOTS];
    logic        if_seen    [IFACES];
    logic [63:0] if_packets [IFACES];
    logic [63:0] if_bytes   [IFACES];
    logic [63:0] if_lat_sum [IFACES];
    logic [63:0] if_lat_min [IFACES];
    logic [63:0] if_lat_max [IFACES];
    logic [63:0] if_hooks   [IFACES][3];
    logic [63:0] hist_count [HIST_SIZE];
    logic [63:0] total_matched;
    logic [63:0] total_latency;

    plt_pkg::in_item_t  pending_events[$];
    plt_pkg::out_item_t expected_results[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_receiver;
    int  errors;
    int  n_accepted;
    int  n_checked;
    int  n_matched;
    longint cycle_count;

    // log2 microsecond bucket
    function automatic logic [3:0] latency_bucket(logic [63:0] lat);
        logic [63:0] us;
        logic [3:0]  b;
        us = lat / 64'd1000;
        b = 4'd0;
        if (us >= 64'd16384) begin
            return 4'd15;
        end
        while (us != 64'd0) begin
            b = b + 4'd1;
            us = us >> 1;
        end
        return b;
    endfunction

    // apply one event to the predicted state and give its result
    function automatic plt_pkg::out_item_t predict_event(plt_pkg::in_item_t ev);
        plt_pkg::out_item_t r;
        int          slot;
        int          ifc;
        logic [63:0] lat;
        logic        hit;
        r = '0;
        lat = '0;
        hit = 1'b0;
        if (ev.opcode == plt_pkg::OP_READ) begin
            ifc = ev.stat_index;
            if (ev.stat_select == plt_pkg::SEL_HIST) begin
                r.read_data = (ev.stat_index < HIST_SIZE) ? hist_count[ev.stat_index] : '0;
            end else if (ev.stat_select == plt_pkg::SEL_GLB_CNT) begin
                r.read_data = total_matched;
            end else if (ev.stat_select == plt_pkg::SEL_GLB_SUM) begin
                r.read_data = total_latency;
            end else if (ev.stat_select <= plt_pkg::SEL_HOOK_EGR && ifc < IFACES
                         && if_seen[ifc]) begin
                case (ev.stat_select)
                    plt_pkg::SEL_PACKETS: r.read_data = if_packets[ifc];
                    plt_pkg::SEL_BYTES:   r.read_data = if_bytes[ifc];
                    plt_pkg::SEL_LAT_SUM: r.read_data = if_lat_sum[ifc];
                    plt_pkg::SEL_LAT_MIN: r.read_data = if_lat_min[ifc];
                    plt_pkg::SEL_LAT_MAX: r.read_data = if_lat_max[ifc];
                    default: r.read_data =
                        if_hooks[ifc][ev.stat_select - plt_pkg::SEL_HOOK_ARR];
                endcase
            end
            return r;
        end
        if (ev.flow_hash == '0) begin
            r.ignored = 1'b1;
            return r;
        end
        slot = ev.flow_hash % SLOTS;
        if (ev.opcode == plt_pkg::OP_ARRIVAL) begin
            slot_valid[slot] = 1'b1;
            slot_tag[slot]   = ev.flow_hash;
            slot_time[slot]  = ev.now_ns;
        end else if (slot_valid[slot] && slot_tag[slot] == ev.flow_hash
                     && slot_time[slot] != '0) begin
            hit = 1'b1;
            lat = ev.now_ns - slot_time[slot];
            r.bucket = latency_bucket(lat);
            hist_count[r.bucket] += 64'd1;
            total_matched += 64'd1;
            total_latency += lat;
            if (ev.opcode == plt_pkg::OP_EGRESS) begin
                slot_valid[slot] = 1'b0;
            end
        end
        // per-interface counters
        ifc = ev.iface;
        if (ifc < IFACES) begin
            if (!if_seen[ifc]) begin
                if_seen[ifc]    = 1'b1;
                if_packets[ifc] = '0;
                if_bytes[ifc]   = '0;
                if_lat_sum[ifc] = '0;
                if_lat_min[ifc] = (lat != '0) ? lat : '1;
                if_lat_max[ifc] = lat;
                for (int h = 0; h < 3; h++) if_hooks[ifc][h] = '0;
            end
            if_packets[ifc] += 64'd1;
            if_bytes[ifc]   += 64'(ev.pkt_len);
            if (lat != '0) begin
                if_lat_sum[ifc] += lat;
                if (lat < if_lat_min[ifc] || if_lat_min[ifc] == '0) if_lat_min[ifc] = lat;
                if (lat > if_lat_max[ifc]) if_lat_max[ifc] = lat;
            end
            if_hooks[ifc][ev.opcode] += 64'd1;
        end
        r.matched = hit;
        r.latency = lat;
        return r;
    endfunction

    function automatic plt_pkg::in_item_t make_event(logic [1:0] op, logic [31:0] hash,
                                                     logic [63:0] now);
        plt_pkg::in_item_t ev;
        ev.opcode      = op;
        ev.flow_hash   = hash;
        ev.iface       = 8'($urandom_range(0, 7));
        ev.pkt_len     = 16'($urandom);
        ev.now_ns      = now;
        ev.stat_select = 4'($urandom);
        ev.stat_index  = 8'($urandom);
        return ev;
    endfunction

    function automatic plt_pkg::in_item_t make_read(logic [3:0] sel, logic [7:0] idx);
        plt_pkg::in_item_t ev;
        logic [159:0]      raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        ev = raw[$bits(plt_pkg::in_item_t)-1:0];
        ev.opcode      = plt_pkg::OP_READ;
        ev.stat_select = sel;
        ev.stat_index  = idx;
        return ev;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else if (!s_valid || s_ready) begin
            if (pending_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_events.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_receiver && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: predict on input transactions, compare on result transactions
    always @(posedge aclk) begin
        plt_pkg::out_item_t exp_r;
        if (aresetn) begin
            cycle_count++;
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_event(s_data));
                n_accepted++;
            end
            if (m_valid && m_ready) begin
                n_checked++;
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_data.matched) n_matched++;
                    if (m_data.ignored !== exp_r.ignored) begin
                        $error("ignored: expected %0d actual %0d", exp_r.ignored, m_data.ignored);
                        errors++;
                    end
                    if (m_data.matched !== exp_r.matched) begin
                        $error("matched: expected %0d actual %0d", exp_r.matched, m_data.matched);
                        errors++;
                    end
                    if (m_data.latency !== exp_r.latency) begin
                        $error("latency: expected %0h actual %0h",
                               exp_r.latency, m_data.latency);
                        errors++;
                    end
                    if (m_data.bucket !== exp_r.bucket) begin
                        $error("bucket: expected %0d actual %0d", exp_r.bucket, m_data.bucket);
                        errors++;
                    end
                    if (m_data.read_data !== exp_r.read_data) begin
                        $error("read_data: expected %0h actual %0h",
                               exp_r.read_data, m_data.read_data);
                        errors++;
                    end
                end
            end
        end
    end

    // timeout
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        int held;
        hold_receiver = 1'b0;
        wait (n_accepted > 100);
        hold_receiver = 1'b1;
        held = 0;
        while (held < 300) begin
            @(posedge aclk);
            held++;
        end
        hold_receiver = 1'b0;
    end

    // stimulus
    initial begin
        logic [63:0] clock_ns;
        logic [31:0] flows[$];
        logic [31:0] h;
        int          phase_len;
        int          pick;
        aresetn = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        errors = 0;
        n_accepted = 0;
        n_checked = 0;
        n_matched = 0;
        cycle_count = 0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0; slot_tag[i] = '0; slot_time[i] = '0;
        end
        for (int i = 0; i < IFACES; i++) if_seen[i] = 1'b0;
        for (int i = 0; i < HIST_SIZE; i++) hist_count[i] = '0;
        total_matched = '0;
        total_latency = '0;

        // directed: zero hash, zero stored time, zero latency, extremes,
        // bucket edges, out of range selectors and indexes, wrap of latency
        pending_events.push_back(make_event(plt_pkg::OP_ARRIVAL, 32'h0, 64'd5));
        pending_events.push_back(make_event(plt_pkg::OP_EGRESS, 32'h0, 64'd5));
        pending_events.push_back(make_event(plt_pkg::OP_ARRIVAL, 32'h0000_0123, 64'd0));
        pending_events.push_back(make_event(plt_pkg::OP_INGRESS, 32'h0000_0123, 64'd900));
        pending_events.push_back(make_event(plt_pkg::OP_EGRESS, 32'h0000_0123, 64'd900));
        pending_events.push_back(make_event(plt_pkg::OP_ARRIVAL, 32'hFFFF_FFFF, 64'd7000));
        pending_events.push_back(make_event(plt_pkg::OP_INGRESS, 32'hFFFF_FFFF, 64'd7000));
        pending_events.push_back(make_event(plt_pkg::OP_INGRESS, 32'hFFFF_FFFF, 64'd8999));
        pending_events.push_back(make_event(plt_pkg::OP_EGRESS, 32'hFFFF_FFFF,
                                            64'd16391000));
        pending_events.push_back(make_event(plt_pkg::OP_INGRESS, 32'hFFFF_FFFF, 64'd9));
        pending_events.push_back(make_event(plt_pkg::OP_ARRIVAL, 32'h8000_0FFF, '1));
        pending_events.push_back(make_event(plt_pkg::OP_EGRESS, 32'h8000_0FFF, 64'd1));
        pending_events.push_back(make_event(plt_pkg::OP_ARRIVAL, 32'h1234_5001, 64'd100));
        pending_events.push_back(make_event(plt_pkg::OP_INGRESS, 32'h9999_5001, 64'd200));
        begin
            plt_pkg::in_item_t ev;
            ev = make_event(plt_pkg::OP_INGRESS, 32'h7, 64'd3);
            ev.iface = 8'hFF;
            ev.pkt_len = 16'hFFFF;
            pending_events.push_back(ev);
        end
        for (int s = 0; s < 16; s++) begin
            pending_events.push_back(make_read(4'(s), 8'($urandom_range(0, 7))));
        end
        pending_events.push_back(make_read(plt_pkg::SEL_HIST, 8'd15));
        pending_events.push_back(make_read(plt_pkg::SEL_HIST, 8'd16));
        pending_events.push_back(make_read(plt_pkg::SEL_PACKETS, 8'hFF));
        pending_events.push_back(make_read(plt_pkg::SEL_LAT_MIN, 8'd200));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // random: mostly arrival then ingress/egress of the same flow
        clock_ns = 64'd1;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            phase_len = N_RANDOM / 4;
            for (int n = 0; n < phase_len; n++) begin
                pick = $urandom_range(0, 99);
                clock_ns += 64'($urandom_range(0, 3000000));
                if ($urandom_range(0, 19) == 0) clock_ns = {$urandom, $urandom};
                if (pick < 30 || flows.size() == 0) begin
                    h = $urandom;
                    if ($urandom_range(0, 9) == 0) h = 32'h0;
                    pending_events.push_back(make_event(plt_pkg::OP_ARRIVAL, h, clock_ns));
                    if (h != 0) flows.push_back(h);
                    if (flows.size() > 20) void'(flows.pop_front());
                end else if (pick < 75) begin
                    h = flows[$urandom_range(0, flows.size() - 1)];
                    pending_events.push_back(make_event(
                        $urandom_range(0, 1) ? plt_pkg::OP_EGRESS : plt_pkg::OP_INGRESS,
                        h, clock_ns));
                end else if (pick < 85) begin
                    pending_events.push_back(make_event(2'($urandom_range(0, 2)), $urandom,
                                                        {$urandom, $urandom}));
                end else begin
                    pending_events.push_back(make_read(4'($urandom_range(0, 15)),
                        $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 15))));
                end
            end
            while (pending_events.size() != 0 || s_valid || expected_results.size() != 0) begin
                @(posedge aclk);
            end
        end
        // final sweep of all statistics
        for (int s = 0; s < 11; s++) pending_events.push_back(make_read(4'(s), 8'd3));
        while (pending_events.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);

        $display("covered %0d events, %0d results checked, %0d latency matches",
                 n_accepted, n_checked, n_matched);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
